// File: hdl/ffca_pkg.sv
package ffca_pkg;

	// Default sizes, handed to the top level parameters.
	localparam int FFCA_ADDR_BITS  = 32;
	localparam int FFCA_MAX_BLOCKS = 64;
	localparam int FFCA_MAX_SPANS  = 16;

	// Field widths follow from the 32-bit byte address and 16-byte units.
	localparam int UNIT_W = 28;
	localparam int CS_W   = 29;
	localparam int SPAN_W = 8;
	localparam int ALU_W  = 34;

	localparam logic [2:0] CMD_GROW   = 3'd0;
	localparam logic [2:0] CMD_ALLOC  = 3'd1;
	localparam logic [2:0] CMD_FREE   = 3'd2;
	localparam logic [2:0] CMD_SHRINK = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_FIT    = 3'd1;
	localparam logic [2:0] ST_NOT_LIVE  = 3'd2;
	localparam logic [2:0] ST_SPAN_FULL = 3'd3;
	localparam logic [2:0] ST_REFUSED   = 3'd4;
	localparam logic [2:0] ST_BAD       = 3'd5;
	localparam logic [2:0] ST_BLK_FULL  = 3'd6;

	typedef struct packed {
		logic [SPAN_W-1:0] span;
		logic [CS_W-1:0]   cs;
		logic [UNIT_W-1:0] unit;
	} blk_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             lt;
		logic             eq;
	} alu_res_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP,
		S_AF_RD, S_AF_CMP, S_AF_MN, S_AF_MP, S_AF_SUMN, S_AF_APPLY, S_AF_RET,
		S_RM_RD, S_RM_WR, S_INS_RD, S_INS_WR,
		S_AL_RD, S_AL_CMP, S_AL_SPLIT, S_AL_LIVE,
		S_FR_RD, S_FR_CMP, S_FR_MV_RD, S_FR_MV_WR,
		S_SH_RD, S_SH_C1, S_SH_C2, S_SF_RD, S_SF_C1, S_SF_C2,
		S_CL_NEXT, S_FIN
	} state_t;

	typedef enum logic [1:0] {RET_GROW, RET_FREE, RET_CLEAR} ret_t;

	typedef enum logic {RM_AF, RM_AL} rm_ret_t;

endpackage

// File: hdl/ffca_ram.sv
module ffca_ram import ffca_pkg::*; #(
	parameter int DEPTH = FFCA_MAX_BLOCKS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  blk_t          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output blk_t          rdata
);

	blk_t mem_q [DEPTH];

	// Read data is registered and holds while no read is issued.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/ffca_alu.sv
module ffca_alu import ffca_pkg::*; (
	input  logic [ALU_W-1:0] x,
	input  logic [ALU_W-1:0] y,
	input  logic [ALU_W-1:0] z,
	output alu_res_t         res
);

	logic [ALU_W-1:0] sum;

	// One adder followed by one magnitude and equality compare.
	assign sum     = x + y;
	assign res.sum = sum;
	assign res.lt  = sum < z;
	assign res.eq  = sum == z;

endmodule

// File: hdl/first_fit_coalescing_allocator.sv
// First-fit free-list heap allocator with coalescing, 16-byte units, one request at a time.
// A request refused at decode goes straight to its result; the others walk the tables entry by
// entry, and the longest walk is a shrink over full tables.
// Requests are taken one at a time; a new request is taken while a result waits.
// Reset: counts and the sequencer clear at once; the span table is not cleared, and no
// clearing pass runs.
module first_fit_coalescing_allocator import ffca_pkg::*; #(
	parameter int ADDR_BITS  = FFCA_ADDR_BITS,
	parameter int MAX_BLOCKS = FFCA_MAX_BLOCKS,
	parameter int MAX_SPANS  = FFCA_MAX_SPANS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [31:0] addr_in,
	input  logic [31:0] size_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] addr_out,
	output logic [31:0] size_out
);

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int SIDX_W = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
	localparam int SCNT_W = $clog2(MAX_SPANS + 1);
	localparam logic [32:0] SPACE_LIMIT =
		33'(64'd1 << ((ADDR_BITS < 32) ? ADDR_BITS : 32));

	// Splits a span into its first whole unit and the count of whole units behind it.
	function automatic blk_t carve(input logic [31:0] base, input logic [31:0] size,
			input logic [SPAN_W-1:0] idx);
		logic [3:0]  pad;
		logic [31:0] rest;
		blk_t        b;
		pad    = ~base[3:0] + 4'd1;
		rest   = size - {28'd0, pad};
		b.unit = base[31:4] + UNIT_W'(|base[3:0]);
		b.cs   = {1'b0, rest[31:4]};
		b.span = idx;
		return b;
	endfunction

	// Sequencer and control state.
	state_t            state_q, state_d;
	ret_t              ret_q, ret_d;
	rm_ret_t           rm_ret_q, rm_ret_d;
	logic [CNT_W-1:0]  fc_q, fc_d, lc_q, lc_d;
	logic [CNT_W-1:0]  p_q, p_d, j_q, j_d, k_q, k_d;
	logic [SCNT_W-1:0] st_q, st_d, sidx_q, sidx_d;
	logic              out_valid_q, out_valid_d;

	// Working registers.
	logic [2:0]        cmd_q, cmd_d;
	logic [31:0]       a_q, a_d, s_q, s_d;
	blk_t              b_q, b_d, prev_q, prev_d, next_q, next_d, got_q, got_d;
	logic              prev_v_q, prev_v_d, next_v_q, next_v_d;
	logic              mn_q, mn_d, mp_q, mp_d, af_ok_q, af_ok_d, ge_q, ge_d;
	logic [CS_W-1:0]   need_q, need_d;
	logic [UNIT_W-1:0] hu_q, hu_d;
	logic [31:0]       lo_q, lo_d, sz_q, sz_d;
	logic [32:0]       hi_q, hi_d;
	logic [2:0]        res_status_q, res_status_d, status_q, status_d;
	logic [31:0]       res_addr_q, res_addr_d, res_size_q, res_size_d;
	logic [31:0]       addr_out_q, addr_out_d, size_out_q, size_out_d;

	// Span table, read through one index.
	logic [31:0]       span_base_q [MAX_SPANS];
	logic [31:0]       span_size_q [MAX_SPANS];
	logic              sp_we;
	logic [SIDX_W-1:0] sp_ridx;
	logic [31:0]       sp_rbase, sp_rsize;
	logic [SCNT_W-1:0] st_dec;

	// Table ports and the shared adder and comparator.
	logic              f_we, f_re, l_we, l_re;
	logic [IDX_W-1:0]  f_waddr, f_raddr, l_waddr, l_raddr;
	blk_t              f_wdata, f_rdata, l_wdata, l_rdata;
	logic [ALU_W-1:0]  alu_x, alu_y, alu_z;
	alu_res_t          alu;

	logic [CNT_W-1:0]  j_inc, j_dec, p_dec, lc_dec;
	logic [32:0]       grow_end;
	logic [3:0]        grow_pad;
	logic              grow_bad;
	logic              mp_now;

	assign j_inc  = j_q + CNT_W'(1);
	assign j_dec  = j_q - CNT_W'(1);
	assign p_dec  = p_q - CNT_W'(1);
	assign lc_dec = lc_q - CNT_W'(1);
	assign st_dec = st_q - SCNT_W'(1);

	// A grow request is refused when the span is empty, starts at zero, runs past the
	// address space, or holds no whole unit once its base is aligned up.
	assign grow_end = {1'b0, a_q} + {1'b0, s_q};
	assign grow_pad = ~a_q[3:0] + 4'd1;
	assign grow_bad = (s_q == 32'd0) || (a_q == 32'd0) || (grow_end > SPACE_LIMIT) ||
		(s_q < {27'd0, 1'b1, grow_pad});

	// Shrink reads the last span while decoding; clear walks the spans by index.
	assign sp_ridx  = (state_q == S_DISP) ? st_dec[SIDX_W-1:0] : sidx_q[SIDX_W-1:0];
	assign sp_rbase = span_base_q[sp_ridx];
	assign sp_rsize = span_size_q[sp_ridx];

	assign mp_now = prev_v_q && (prev_q.span == b_q.span) && alu.eq;

	ffca_ram #(.DEPTH(MAX_BLOCKS)) u_free (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.re    (f_re),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	ffca_ram #(.DEPTH(MAX_BLOCKS)) u_live (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.re    (l_re),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	ffca_alu u_alu (
		.x   (alu_x),
		.y   (alu_y),
		.z   (alu_z),
		.res (alu)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign addr_out  = addr_out_q;
	assign size_out  = size_out_q;

	// The free table is kept in address order. Inserting a block first scans for the
	// first entry whose header is not below it, then checks whether the block touches
	// its neighbors in the same span. Touching blocks merge in place; a merge on both
	// sides also removes the upper neighbor by shifting the tail down one entry, and
	// a block with no neighbor shifts the tail up to make room.
	always_comb begin
		state_d      = state_q;
		ret_d        = ret_q;
		rm_ret_d     = rm_ret_q;
		fc_d         = fc_q;
		lc_d         = lc_q;
		p_d          = p_q;
		j_d          = j_q;
		k_d          = k_q;
		st_d         = st_q;
		sidx_d       = sidx_q;
		out_valid_d  = out_valid_q;
		cmd_d        = cmd_q;
		a_d          = a_q;
		s_d          = s_q;
		b_d          = b_q;
		prev_d       = prev_q;
		next_d       = next_q;
		got_d        = got_q;
		prev_v_d     = prev_v_q;
		next_v_d     = next_v_q;
		mn_d         = mn_q;
		mp_d         = mp_q;
		af_ok_d      = af_ok_q;
		ge_d         = ge_q;
		need_d       = need_q;
		hu_d         = hu_q;
		lo_d         = lo_q;
		hi_d         = hi_q;
		sz_d         = sz_q;
		res_status_d = res_status_q;
		res_addr_d   = res_addr_q;
		res_size_d   = res_size_q;
		status_d     = status_q;
		addr_out_d   = addr_out_q;
		size_out_d   = size_out_q;
		sp_we        = 1'b0;
		f_we         = 1'b0;
		f_waddr      = '0;
		f_wdata      = b_q;
		f_re         = 1'b0;
		f_raddr      = '0;
		l_we         = 1'b0;
		l_waddr      = '0;
		l_wdata      = got_q;
		l_re         = 1'b0;
		l_raddr      = '0;
		alu_x        = '0;
		alu_y        = '0;
		alu_z        = '0;

		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_d   = command;
					a_d     = addr_in;
					s_d     = size_in;
					state_d = S_DISP;
				end
			end

			S_DISP: begin
				res_status_d = ST_OK;
				res_addr_d   = 32'd0;
				res_size_d   = 32'd0;
				unique case (cmd_q)
					CMD_GROW: begin
						if (grow_bad) begin
							res_status_d = ST_BAD;
							state_d      = S_FIN;
						end else if (st_q == SCNT_W'(MAX_SPANS)) begin
							res_status_d = ST_SPAN_FULL;
							state_d      = S_FIN;
						end else if (fc_q == CNT_W'(MAX_BLOCKS)) begin
							res_status_d = ST_BLK_FULL;
							state_d      = S_FIN;
						end else begin
							sp_we    = 1'b1;
							st_d     = st_q + SCNT_W'(1);
							b_d      = carve(a_q, s_q, SPAN_W'(st_q));
							ret_d    = RET_GROW;
							p_d      = '0;
							prev_v_d = 1'b0;
							state_d  = S_AF_RD;
						end
					end
					CMD_ALLOC: begin
						if (s_q == 32'd0) begin
							res_status_d = ST_BAD;
							state_d      = S_FIN;
						end else if (lc_q == CNT_W'(MAX_BLOCKS)) begin
							res_status_d = ST_BLK_FULL;
							state_d      = S_FIN;
						end else begin
							need_d  = {1'b0, s_q[31:4]} + CS_W'(|s_q[3:0]) + CS_W'(1);
							p_d     = '0;
							state_d = S_AL_RD;
						end
					end
					CMD_FREE: begin
						if ((a_q < 32'd16) || (a_q[3:0] != 4'd0)) begin
							res_status_d = ST_NOT_LIVE;
							state_d      = S_FIN;
						end else begin
							hu_d    = a_q[31:4] - UNIT_W'(1);
							k_d     = '0;
							state_d = S_FR_RD;
						end
					end
					CMD_SHRINK: begin
						if (st_q == '0) begin
							res_status_d = ST_REFUSED;
							state_d      = S_FIN;
						end else begin
							sidx_d  = st_dec;
							lo_d    = sp_rbase;
							sz_d    = sp_rsize;
							hi_d    = {1'b0, sp_rbase} + {1'b0, sp_rsize};
							p_d     = '0;
							state_d = S_SH_RD;
						end
					end
					CMD_CLEAR: begin
						lc_d    = '0;
						fc_d    = '0;
						sidx_d  = '0;
						state_d = S_CL_NEXT;
					end
					default: begin
						res_status_d = ST_BAD;
						state_d      = S_FIN;
					end
				endcase
			end

			// Scan for the insertion point, keeping the entry just below it.
			S_AF_RD: begin
				if (p_q < fc_q) begin
					f_re    = 1'b1;
					f_raddr = p_q[IDX_W-1:0];
					state_d = S_AF_CMP;
				end else begin
					next_v_d = 1'b0;
					state_d  = S_AF_MN;
				end
			end
			S_AF_CMP: begin
				alu_x = ALU_W'(f_rdata.unit);
				alu_z = ALU_W'(b_q.unit);
				if (alu.lt) begin
					prev_d   = f_rdata;
					prev_v_d = 1'b1;
					p_d      = p_q + CNT_W'(1);
					state_d  = S_AF_RD;
				end else begin
					next_d   = f_rdata;
					next_v_d = 1'b1;
					state_d  = S_AF_MN;
				end
			end
			S_AF_MN: begin
				alu_x   = ALU_W'(b_q.unit);
				alu_y   = ALU_W'(b_q.cs);
				alu_z   = ALU_W'(next_q.unit);
				mn_d    = next_v_q && (next_q.span == b_q.span) && alu.eq;
				state_d = S_AF_MP;
			end
			S_AF_MP: begin
				alu_x = ALU_W'(prev_q.unit);
				alu_y = ALU_W'(prev_q.cs);
				alu_z = ALU_W'(b_q.unit);
				mp_d  = mp_now;
				if (!mn_q && !mp_now && (fc_q == CNT_W'(MAX_BLOCKS))) begin
					af_ok_d = 1'b0;
					state_d = S_AF_RET;
				end else if (mn_q) begin
					state_d = S_AF_SUMN;
				end else begin
					state_d = S_AF_APPLY;
				end
			end
			S_AF_SUMN: begin
				alu_x   = ALU_W'(b_q.cs);
				alu_y   = ALU_W'(next_q.cs);
				b_d.cs  = alu.sum[CS_W-1:0];
				state_d = S_AF_APPLY;
			end
			S_AF_APPLY: begin
				if (mp_q) begin
					alu_x      = ALU_W'(prev_q.cs);
					alu_y      = ALU_W'(b_q.cs);
					f_we       = 1'b1;
					f_waddr    = p_dec[IDX_W-1:0];
					f_wdata    = prev_q;
					f_wdata.cs = alu.sum[CS_W-1:0];
					if (mn_q) begin
						j_d      = p_q;
						rm_ret_d = RM_AF;
						state_d  = S_RM_RD;
					end else begin
						af_ok_d = 1'b1;
						state_d = S_AF_RET;
					end
				end else if (mn_q) begin
					f_we    = 1'b1;
					f_waddr = p_q[IDX_W-1:0];
					f_wdata = b_q;
					af_ok_d = 1'b1;
					state_d = S_AF_RET;
				end else begin
					j_d     = fc_q;
					state_d = S_INS_RD;
				end
			end

			// Remove entry j by moving every later entry down one place.
			S_RM_RD: begin
				if (j_inc < fc_q) begin
					f_re    = 1'b1;
					f_raddr = j_inc[IDX_W-1:0];
					state_d = S_RM_WR;
				end else begin
					fc_d = fc_q - CNT_W'(1);
					if (rm_ret_q == RM_AF) begin
						af_ok_d = 1'b1;
						state_d = S_AF_RET;
					end else begin
						state_d = S_AL_LIVE;
					end
				end
			end
			S_RM_WR: begin
				f_we    = 1'b1;
				f_waddr = j_q[IDX_W-1:0];
				f_wdata = f_rdata;
				j_d     = j_inc;
				state_d = S_RM_RD;
			end

			// Open a hole at p by moving entries up from the top, then fill it.
			S_INS_RD: begin
				if (j_q > p_q) begin
					f_re    = 1'b1;
					f_raddr = j_dec[IDX_W-1:0];
					state_d = S_INS_WR;
				end else begin
					f_we    = 1'b1;
					f_waddr = p_q[IDX_W-1:0];
					f_wdata = b_q;
					fc_d    = fc_q + CNT_W'(1);
					af_ok_d = 1'b1;
					state_d = S_AF_RET;
				end
			end
			S_INS_WR: begin
				f_we    = 1'b1;
				f_waddr = j_q[IDX_W-1:0];
				f_wdata = f_rdata;
				j_d     = j_dec;
				state_d = S_INS_RD;
			end

			S_AF_RET: begin
				unique case (ret_q)
					RET_GROW: begin
						state_d = S_FIN;
					end
					RET_FREE: begin
						if (af_ok_q) begin
							state_d = S_FR_MV_RD;
						end else begin
							res_status_d = ST_BLK_FULL;
							state_d      = S_FIN;
						end
					end
					RET_CLEAR: begin
						if (!af_ok_q) begin
							res_status_d = ST_BLK_FULL;
						end
						sidx_d  = sidx_q + SCNT_W'(1);
						state_d = S_CL_NEXT;
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end

			// First fit: the first free block, in address order, that is large enough.
			S_AL_RD: begin
				if (p_q < fc_q) begin
					f_re    = 1'b1;
					f_raddr = p_q[IDX_W-1:0];
					state_d = S_AL_CMP;
				end else begin
					res_status_d = ST_NO_FIT;
					state_d      = S_FIN;
				end
			end
			S_AL_CMP: begin
				alu_x = ALU_W'(f_rdata.cs);
				alu_z = ALU_W'(need_q);
				if (alu.lt) begin
					p_d     = p_q + CNT_W'(1);
					state_d = S_AL_RD;
				end else begin
					got_d   = f_rdata;
					state_d = S_AL_SPLIT;
				end
			end
			S_AL_SPLIT: begin
				// Split only when at least two units would be left over.
				alu_x = ALU_W'(need_q);
				alu_y = ALU_W'(1);
				alu_z = ALU_W'(got_q.cs);
				if (alu.lt) begin
					f_we         = 1'b1;
					f_waddr      = p_q[IDX_W-1:0];
					f_wdata.span = got_q.span;
					f_wdata.cs   = got_q.cs - need_q;
					f_wdata.unit = got_q.unit + UNIT_W'(need_q);
					got_d.cs     = need_q;
					state_d      = S_AL_LIVE;
				end else begin
					j_d      = p_q;
					rm_ret_d = RM_AL;
					state_d  = S_RM_RD;
				end
			end
			S_AL_LIVE: begin
				l_we       = 1'b1;
				l_waddr    = lc_q[IDX_W-1:0];
				l_wdata    = got_q;
				lc_d       = lc_q + CNT_W'(1);
				res_addr_d = {got_q.unit + UNIT_W'(1), 4'b0000};
				state_d    = S_FIN;
			end

			// Free looks up the header among live blocks, then moves the last live
			// entry into the emptied slot once the block has joined the free table.
			S_FR_RD: begin
				if (k_q < lc_q) begin
					l_re    = 1'b1;
					l_raddr = k_q[IDX_W-1:0];
					state_d = S_FR_CMP;
				end else begin
					res_status_d = ST_NOT_LIVE;
					state_d      = S_FIN;
				end
			end
			S_FR_CMP: begin
				alu_x = ALU_W'(l_rdata.unit);
				alu_z = ALU_W'(hu_q);
				if (alu.eq) begin
					b_d      = l_rdata;
					ret_d    = RET_FREE;
					p_d      = '0;
					prev_v_d = 1'b0;
					state_d  = S_AF_RD;
				end else begin
					k_d     = k_q + CNT_W'(1);
					state_d = S_FR_RD;
				end
			end
			S_FR_MV_RD: begin
				l_re    = 1'b1;
				l_raddr = lc_dec[IDX_W-1:0];
				state_d = S_FR_MV_WR;
			end
			S_FR_MV_WR: begin
				l_we    = 1'b1;
				l_waddr = k_q[IDX_W-1:0];
				l_wdata = l_rdata;
				lc_d    = lc_dec;
				state_d = S_FIN;
			end

			// Shrink is refused if any live block sits in the last span or
			// belongs to it.
			S_SH_RD: begin
				if (p_q < lc_q) begin
					l_re    = 1'b1;
					l_raddr = p_q[IDX_W-1:0];
					state_d = S_SH_C1;
				end else begin
					p_d     = '0;
					j_d     = '0;
					state_d = S_SF_RD;
				end
			end
			S_SH_C1: begin
				alu_x = ALU_W'({l_rdata.unit, 4'b0000});
				alu_z = ALU_W'(lo_q);
				ge_d  = !alu.lt;
				if (l_rdata.span == SPAN_W'(sidx_q)) begin
					res_status_d = ST_REFUSED;
					state_d      = S_FIN;
				end else begin
					state_d = S_SH_C2;
				end
			end
			S_SH_C2: begin
				alu_x = ALU_W'({l_rdata.unit, 4'b0000});
				alu_z = ALU_W'(hi_q);
				if (ge_q && alu.lt) begin
					res_status_d = ST_REFUSED;
					state_d      = S_FIN;
				end else begin
					p_d     = p_q + CNT_W'(1);
					state_d = S_SH_RD;
				end
			end

			// Compact the free table, dropping blocks whose header lies in the span.
			S_SF_RD: begin
				if (p_q < fc_q) begin
					f_re    = 1'b1;
					f_raddr = p_q[IDX_W-1:0];
					state_d = S_SF_C1;
				end else begin
					fc_d       = j_q;
					st_d       = st_dec;
					res_addr_d = lo_q;
					res_size_d = sz_q;
					state_d    = S_FIN;
				end
			end
			S_SF_C1: begin
				alu_x   = ALU_W'({f_rdata.unit, 4'b0000});
				alu_z   = ALU_W'(lo_q);
				ge_d    = !alu.lt;
				state_d = S_SF_C2;
			end
			S_SF_C2: begin
				alu_x = ALU_W'({f_rdata.unit, 4'b0000});
				alu_z = ALU_W'(hi_q);
				if (!(ge_q && alu.lt)) begin
					f_we    = 1'b1;
					f_waddr = j_q[IDX_W-1:0];
					f_wdata = f_rdata;
					j_d     = j_q + CNT_W'(1);
				end
				p_d     = p_q + CNT_W'(1);
				state_d = S_SF_RD;
			end

			// Clear carves every span again, in index order.
			S_CL_NEXT: begin
				if (sidx_q < st_q) begin
					b_d      = carve(sp_rbase, sp_rsize, SPAN_W'(sidx_q));
					ret_d    = RET_CLEAR;
					p_d      = '0;
					prev_v_d = 1'b0;
					state_d  = S_AF_RD;
				end else begin
					state_d = S_FIN;
				end
			end

			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					status_d    = res_status_q;
					addr_out_d  = res_addr_q;
					size_out_d  = res_size_q;
					state_d     = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= RET_GROW;
			rm_ret_q    <= RM_AF;
			fc_q        <= '0;
			lc_q        <= '0;
			p_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			st_q        <= '0;
			sidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			rm_ret_q    <= rm_ret_d;
			fc_q        <= fc_d;
			lc_q        <= lc_d;
			p_q         <= p_d;
			j_q         <= j_d;
			k_q         <= k_d;
			st_q        <= st_d;
			sidx_q      <= sidx_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q        <= cmd_d;
		a_q          <= a_d;
		s_q          <= s_d;
		b_q          <= b_d;
		prev_q       <= prev_d;
		next_q       <= next_d;
		got_q        <= got_d;
		prev_v_q     <= prev_v_d;
		next_v_q     <= next_v_d;
		mn_q         <= mn_d;
		mp_q         <= mp_d;
		af_ok_q      <= af_ok_d;
		ge_q         <= ge_d;
		need_q       <= need_d;
		hu_q         <= hu_d;
		lo_q         <= lo_d;
		hi_q         <= hi_d;
		sz_q         <= sz_d;
		res_status_q <= res_status_d;
		res_addr_q   <= res_addr_d;
		res_size_q   <= res_size_d;
		status_q     <= status_d;
		addr_out_q   <= addr_out_d;
		size_out_q   <= size_out_d;
		if (sp_we) begin
			span_base_q[st_q[SIDX_W-1:0]] <= a_q;
			span_size_q[st_q[SIDX_W-1:0]] <= s_q;
		end
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import ffca_pkg::*;

	localparam int NBLK      = FFCA_MAX_BLOCKS;
	localparam int NSPAN     = FFCA_MAX_SPANS;
	localparam int N_RANDOM  = 1130;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;

	// Command codes that the block does not define; it must answer them as bad requests.
	localparam logic [2:0] CMD_UNUSED5 = 3'd5;
	localparam logic [2:0] CMD_UNUSED6 = 3'd6;
	localparam logic [2:0] CMD_UNUSED7 = 3'd7;

	typedef struct {
		logic [2:0]  st;
		logic [31:0] ad;
		logic [31:0] sz;
	} alloc_res_t;

	typedef struct {
		logic [2:0]  c;
		logic [31:0] a;
		logic [31:0] s;
		bit          chk;
		logic [2:0]  st;
		logic [31:0] ea;
		logic [31:0] es;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  command;
	logic [31:0] addr_in;
	logic [31:0] size_in;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [31:0] addr_out;
	logic [31:0] size_out;

	first_fit_coalescing_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .addr_in(addr_in), .size_in(size_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .addr_out(addr_out), .size_out(size_out)
	);

	// Shadow heap state: free list in address order, live list, span table.
	logic [63:0] fr_u [NBLK];
	logic [63:0] fr_c [NBLK];
	int          fr_s [NBLK];
	int          fr_n;
	logic [63:0] lv_u [NBLK];
	logic [63:0] lv_c [NBLK];
	int          lv_s [NBLK];
	int          lv_n;
	logic [63:0] sp_b [NSPAN];
	logic [63:0] sp_z [NSPAN];
	int          sp_n;

	alloc_res_t  pending_q[$];
	bit          cur_chk;
	alloc_res_t  cur_typed;
	int          errs;
	int          cyc;
	int          idle_cyc;
	bit          quiet;

	// The stretch without any idling on either side.
	assign quiet = (cyc >= 4000) && (cyc < 12000);

	initial begin
		clk = 1'b0;
	end
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void fr_del(int p);
		for (int i = p; i + 1 < fr_n; i++) begin
			fr_u[i] = fr_u[i+1];
			fr_c[i] = fr_c[i+1];
			fr_s[i] = fr_s[i+1];
		end
		fr_n--;
	endfunction

	function automatic void fr_ins(int p, logic [63:0] u, logic [63:0] c, int s);
		for (int i = fr_n; i > p; i--) begin
			fr_u[i] = fr_u[i-1];
			fr_c[i] = fr_c[i-1];
			fr_s[i] = fr_s[i-1];
		end
		fr_u[p] = u;
		fr_c[p] = c;
		fr_s[p] = s;
		fr_n++;
	endfunction

	// Places a block in address order, merging with same-span neighbors. Returns 0 when the
	// free list is full and no merge makes room.
	function automatic bit fr_merge_in(logic [63:0] u, logic [63:0] c, int s);
		int p;
		bit mn;
		bit mp;
		p = 0;
		while (p < fr_n && fr_u[p] < u)
			p++;
		mn = (p < fr_n) && (fr_s[p] == s) && (u + c == fr_u[p]);
		mp = (p > 0) && (fr_s[p-1] == s) && (fr_u[p-1] + fr_c[p-1] == u);
		if (!mn && !mp && fr_n >= NBLK)
			return 1'b0;
		if (mn) begin
			c = c + fr_c[p];
			fr_del(p);
		end
		if (mp)
			fr_c[p-1] = fr_c[p-1] + c;
		else
			fr_ins(p, u, c, s);
		return 1'b1;
	endfunction

	function automatic bit carve_span(int idx);
		logic [63:0] pad;
		pad = (64'd16 - (sp_b[idx] & 64'd15)) & 64'd15;
		return fr_merge_in((sp_b[idx] + pad) >> 4, (sp_z[idx] - pad) >> 4, idx);
	endfunction

	function automatic alloc_res_t heap_predict(logic [2:0] c, logic [31:0] a32, logic [31:0] s32);
		alloc_res_t r;
		logic [63:0] a;
		logic [63:0] s;
		logic [63:0] pad;
		logic [63:0] need;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] h;
		int p;
		int k;
		int last;
		bit hit;
		bit busy;
		a = {32'd0, a32};
		s = {32'd0, s32};
		r.st = ST_OK;
		r.ad = '0;
		r.sz = '0;
		case (c)
			CMD_GROW: begin
				pad = (64'd16 - (a & 64'd15)) & 64'd15;
				if (s == 0 || a == 0 || a + s > 64'h1_0000_0000 || pad >= s ||
				    ((s - pad) >> 4) == 0)
					r.st = ST_BAD;
				else if (sp_n >= NSPAN)
					r.st = ST_SPAN_FULL;
				else if (fr_n >= NBLK)
					r.st = ST_BLK_FULL;
				else begin
					sp_b[sp_n] = a;
					sp_z[sp_n] = s;
					sp_n++;
					void'(carve_span(sp_n - 1));
				end
			end
			CMD_ALLOC: begin
				need = ((s + 64'd15) >> 4) + 64'd1;
				if (s == 0)
					r.st = ST_BAD;
				else if (lv_n >= NBLK)
					r.st = ST_BLK_FULL;
				else begin
					p = 0;
					while (p < fr_n && fr_c[p] < need)
						p++;
					if (p >= fr_n)
						r.st = ST_NO_FIT;
					else begin
						lv_u[lv_n] = fr_u[p];
						lv_s[lv_n] = fr_s[p];
						if (fr_c[p] > need + 1) begin
							lv_c[lv_n] = need;
							fr_u[p] = fr_u[p] + need;
							fr_c[p] = fr_c[p] - need;
						end else begin
							lv_c[lv_n] = fr_c[p];
							fr_del(p);
						end
						r.ad = 32'((lv_u[lv_n] + 64'd1) << 4);
						lv_n++;
					end
				end
			end
			CMD_FREE: begin
				hit = 1'b0;
				k = 0;
				if (a >= 64'd16 && (a & 64'd15) == 0) begin
					for (k = 0; k < lv_n; k++)
						if (lv_u[k] == (a >> 4) - 64'd1) begin
							hit = 1'b1;
							break;
						end
				end
				if (!hit)
					r.st = ST_NOT_LIVE;
				else if (!fr_merge_in(lv_u[k], lv_c[k], lv_s[k]))
					r.st = ST_BLK_FULL;
				else begin
					lv_u[k] = lv_u[lv_n-1];
					lv_c[k] = lv_c[lv_n-1];
					lv_s[k] = lv_s[lv_n-1];
					lv_n--;
				end
			end
			CMD_SHRINK: begin
				if (sp_n == 0)
					r.st = ST_REFUSED;
				else begin
					last = sp_n - 1;
					lo = sp_b[last];
					hi = lo + sp_z[last];
					busy = 1'b0;
					for (int i = 0; i < lv_n; i++) begin
						h = lv_u[i] << 4;
						if ((h >= lo && h < hi) || lv_s[i] == last)
							busy = 1'b1;
					end
					if (busy)
						r.st = ST_REFUSED;
					else begin
						p = 0;
						while (p < fr_n) begin
							h = fr_u[p] << 4;
							if (h >= lo && h < hi)
								fr_del(p);
							else
								p++;
						end
						r.ad = lo[31:0];
						r.sz = sp_z[last][31:0];
						sp_n = last;
					end
				end
			end
			CMD_CLEAR: begin
				lv_n = 0;
				fr_n = 0;
				for (int i = 0; i < sp_n; i++)
					if (!carve_span(i))
						r.st = ST_BLK_FULL;
			end
			default: r.st = ST_BAD;
		endcase
		return r;
	endfunction

	// Input acceptance, result checking and the stall watchdog, all on the rising edge.
	always @(posedge clk) begin
		alloc_res_t e;
		alloc_res_t p;
		cyc <= cyc + 1;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_q.size() == 0) begin
					$display("%0t: unexpected result st=%0d addr=%h size=%h", $time,
					         status, addr_out, size_out);
					errs++;
				end else begin
					e = pending_q.pop_front();
					if (status !== e.st) begin
						$display("%0t: status expected %0d actual %0d", $time, e.st, status);
						errs++;
					end
					if (addr_out !== e.ad) begin
						$display("%0t: addr_out expected %h actual %h", $time, e.ad, addr_out);
						errs++;
					end
					if (size_out !== e.sz) begin
						$display("%0t: size_out expected %h actual %h", $time, e.sz, size_out);
						errs++;
					end
				end
			end
			if (in_valid && in_ready) begin
				p = heap_predict(command, addr_in, size_in);
				pending_q.push_back(cur_chk ? cur_typed : p);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cyc <= 0;
			else if (idle_cyc + 1 >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else
				idle_cyc <= idle_cyc + 1;
		end
	end

	// The result side stalls at random except during the quiet stretch.
	always @(negedge clk) begin
		out_ready <= quiet || ($urandom_range(99) >= 15);
	end

	// Drives one request at the falling edge and holds it until it is taken.
	task automatic send_request(logic [2:0] c, logic [31:0] a, logic [31:0] s, bit chk,
	                            alloc_res_t typed);
		while (!quiet && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		command   <= c;
		addr_in   <= a;
		size_in   <= s;
		cur_chk   <= chk;
		cur_typed <= typed;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	dir_row_t dir_tab [] = '{
		'{CMD_SHRINK, 32'h0, 32'h0, 1'b1, ST_REFUSED, 32'h0, 32'h0},
		'{CMD_ALLOC, 32'h0, 32'h0, 1'b1, ST_BAD, 32'h0, 32'h0},
		'{CMD_FREE, 32'h0, 32'h0, 1'b1, ST_NOT_LIVE, 32'h0, 32'h0},
		'{CMD_FREE, 32'h8, 32'h0, 1'b1, ST_NOT_LIVE, 32'h0, 32'h0},
		'{CMD_UNUSED5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_BAD, 32'h0, 32'h0},
		'{CMD_UNUSED6, 32'h1000, 32'h1000, 1'b1, ST_BAD, 32'h0, 32'h0},
		'{CMD_UNUSED7, 32'h0, 32'h0, 1'b1, ST_BAD, 32'h0, 32'h0},
		'{CMD_GROW, 32'h1000, 32'h0, 1'b1, ST_BAD, 32'h0, 32'h0},
		'{CMD_GROW, 32'h0, 32'h1000, 1'b1, ST_BAD, 32'h0, 32'h0},
		'{CMD_GROW, 32'hFFFF_FFF0, 32'h20, 1'b1, ST_BAD, 32'h0, 32'h0},
		'{CMD_GROW, 32'h1, 32'h10, 1'b1, ST_BAD, 32'h0, 32'h0},
		'{CMD_GROW, 32'h1, 32'hF, 1'b1, ST_BAD, 32'h0, 32'h0},
		'{CMD_GROW, 32'h1000, 32'h1000, 1'b1, ST_OK, 32'h0, 32'h0},
		'{CMD_ALLOC, 32'h0, 32'h1, 1'b1, ST_OK, 32'h1010, 32'h0},
		'{CMD_ALLOC, 32'h0, 32'hFFFF_FFFF, 1'b1, ST_NO_FIT, 32'h0, 32'h0},
		'{CMD_ALLOC, 32'h0, 32'h30, 1'b0, ST_OK, 32'h0, 32'h0},
		'{CMD_CLEAR, 32'h0, 32'h0, 1'b1, ST_OK, 32'h0, 32'h0},
		'{CMD_ALLOC, 32'h0, 32'h10, 1'b0, ST_OK, 32'h0, 32'h0},
		'{CMD_FREE, 32'h1010, 32'h0, 1'b0, ST_OK, 32'h0, 32'h0},
		'{CMD_FREE, 32'h1010, 32'h0, 1'b1, ST_NOT_LIVE, 32'h0, 32'h0},
		'{CMD_GROW, 32'hFFFF_F000, 32'h1000, 1'b1, ST_OK, 32'h0, 32'h0},
		'{CMD_SHRINK, 32'h0, 32'h0, 1'b1, ST_OK, 32'hFFFF_F000, 32'h1000},
		'{CMD_SHRINK, 32'h0, 32'h0, 1'b1, ST_OK, 32'h1000, 32'h1000},
		'{CMD_SHRINK, 32'h0, 32'h0, 1'b1, ST_REFUSED, 32'h0, 32'h0}
	};

	// Mostly well-formed heap traffic built from the shadow state, with some noise.
	task automatic pick_request(int n, output logic [2:0] c, output logic [31:0] a,
	                            output logic [31:0] s);
		int r;
		int free_w;
		r = $urandom_range(99);
		// One stretch leans on allocation so the live list can fill up.
		free_w = (n >= 600 && n < 760) ? 8 : 32;
		a = $urandom;
		s = $urandom;
		if (sp_n == 0 && r < 50)
			r = 0;
		if (r < 11) begin
			c = CMD_GROW;
			if ($urandom_range(7) != 0) begin
				a = $urandom_range(1, 32'h00FF_FFFF);
				s = $urandom_range(1, 3000);
			end
		end else if (r < 48) begin
			c = CMD_ALLOC;
			case ($urandom_range(29))
				0: s = 32'h0;
				1: s = $urandom;
				default: s = $urandom_range(1, 300);
			endcase
		end else if (r < 48 + free_w) begin
			c = CMD_FREE;
			if (lv_n > 0 && $urandom_range(99) < 85)
				a = 32'((lv_u[$urandom_range(lv_n - 1)] + 64'd1) << 4);
			else if ($urandom_range(1) == 0)
				a = $urandom_range(0, 32'h0100_0000);
		end else if (r < 87 + (32 - free_w)) begin
			c = ($urandom_range(9) == 0) ? CMD_CLEAR : CMD_SHRINK;
		end else if (r < 95) begin
			c = CMD_SHRINK;
		end else begin
			c = 3'($urandom_range(CMD_UNUSED5, CMD_UNUSED7));
		end
	endtask

	initial begin
		logic [2:0]  c;
		logic [31:0] a;
		logic [31:0] s;
		alloc_res_t  t;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		out_ready = 1'b0;
		command   = '0;
		addr_in   = '0;
		size_in   = '0;
		cur_chk   = 1'b0;
		cur_typed = '{default: '0};
		errs      = 0;
		cyc       = 0;
		idle_cyc  = 0;
		fr_n      = 0;
		lv_n      = 0;
		sp_n      = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			t.st = dir_tab[i].st;
			t.ad = dir_tab[i].ea;
			t.sz = dir_tab[i].es;
			send_request(dir_tab[i].c, dir_tab[i].a, dir_tab[i].s, dir_tab[i].chk, t);
		end
		t = '{default: '0};
		for (int n = 0; n < N_RANDOM; n++) begin
			pick_request(n, c, a, s);
			send_request(c, a, s, 1'b0, t);
		end
		in_valid <= 1'b0;

		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errs == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
hdl/ffca_pkg.sv
hdl/ffca_ram.sv
hdl/ffca_alu.sv
hdl/first_fit_coalescing_allocator.sv
dv/tb.sv
